// ===== rtl/bopc_pkg.sv =====
// shared types and constants of the bridge-only path checker
package bopc_pkg;

  localparam int MaxVerticesDef = 32;
  localparam int NodeW          = 5;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_word_t;

  typedef struct packed {
    logic path_exists;
    logic path_unique;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic we;
    logic re;
  } adj_ctrl_t;

endpackage

// ===== rtl/bopc_adj_store.sv =====
// adjacency row memory with per-row valid bits, so one clear empties all rows
module bopc_adj_store #(
  parameter int  MaxVertices = bopc_pkg::MaxVerticesDef,
  localparam int AddrW       = $clog2(MaxVertices)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bopc_pkg::adj_ctrl_t     ctrl_i,
  input  logic [AddrW-1:0]        addr_i,
  input  logic [MaxVertices-1:0]  wdata_i,
  output logic [MaxVertices-1:0]  rdata_o
);
  import bopc_pkg::*;

  logic [MaxVertices-1:0] mem_q [MaxVertices];
  logic [MaxVertices-1:0] vld_q;
  logic [MaxVertices-1:0] rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.we) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (ctrl_i.re) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  // a row never written since the last clear reads as empty
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/bridge_only_path_checker.sv =====
// top level: graph store, dfs bridge search and unique-path decision
//
// usage: drive a word on req_i and raise start_i; it is taken at a clock edge
// where busy_o is low. clear keeps busy_o low, add edge updates two rows, and
// neither gives a result. a query answers with one word on res_o, marked by
// res_valid_o for exactly one cycle; the receiver cannot stall it, so it must
// sample in that cycle. a query with a vertex out of range answers in the
// next cycle with both flags low.
// a query runs a depth-first search over all components: one root check per
// vertex, every vertex row scanned one neighbor bit per cycle from the
// adjacency memory unless a depth lookup holds the scan, plus a retire step
// per vertex, a restore step per tree edge and one depth lookup per back edge.
// then the bridge chains above start and end are walked, each step reading
// the dfs parent of the current vertex. the word appears in the cycle in which
// busy_o falls.
// reset empties the graph at once through row valid bits; no clearing pass.
module bridge_only_path_checker #(
  parameter int MaxVertices = bopc_pkg::MaxVerticesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bopc_pkg::in_word_t  req_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output bopc_pkg::out_word_t res_o
);
  import bopc_pkg::*;

  localparam int VW = $clog2(MaxVertices);
  localparam int CW = VW + 1;

  typedef struct packed {
    logic [VW-1:0] dep;
    logic [VW-1:0] par;
    logic [CW-1:0] nxt;
    logic [VW-1:0] low;
  } vtx_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_ADD_WA  = 10'b0000000010,
    S_ADD_RB  = 10'b0000000100,
    S_ADD_WB  = 10'b0000001000,
    S_ROOT    = 10'b0000010000,
    S_SCAN    = 10'b0000100000,
    S_BACK    = 10'b0001000000,
    S_RESTORE = 10'b0010000000,
    S_WALK    = 10'b0100000000,
    S_WALK_WT = 10'b1000000000
  } state_e;

  state_e                 state_q, state_d;
  in_word_t               req_q, req_d;
  logic [CW-1:0]          r_q, r_d, nxt_q, nxt_d;
  logic [VW-1:0]          v_q, v_d, par_q, par_d, dep_q, dep_d, low_q, low_d;
  logic [VW-1:0]          cl_q, cl_d, x_q, x_d, topa_q, topa_d;
  logic [MaxVertices-1:0] seen_q, seen_d, onp_q, onp_d, brg_q, brg_d, base_q, base_d;
  logic                   got_q, got_d, exist_q, exist_d, phase_q, phase_d;
  logic                   res_valid_q, res_valid_d;
  out_word_t              res_q, res_d;

  adj_ctrl_t              adj_ctrl;
  logic [VW-1:0]          adj_addr;
  logic [MaxVertices-1:0] adj_wdata, adj_rdata, one_v;

  vtx_t                   vtx_mem_q [MaxVertices];
  vtx_t                   vtx_rd_q, vtx_wdata;
  logic                   vtx_we, vtx_re;
  logic [VW-1:0]          vtx_waddr, vtx_raddr;

  logic [VW-1:0]          u, rr, na, na_q, nb_q;
  logic                   in_range;

  bopc_adj_store #(.MaxVertices(MaxVertices)) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (adj_ctrl),
    .addr_i  (adj_addr),
    .wdata_i (adj_wdata),
    .rdata_o (adj_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem_q[vtx_waddr] <= vtx_wdata;
    end
    if (vtx_re) begin
      vtx_rd_q <= vtx_mem_q[vtx_raddr];
    end
  end

  assign one_v    = {{(MaxVertices-1){1'b0}}, 1'b1};
  assign u        = nxt_q[VW-1:0];
  assign rr       = r_q[VW-1:0];
  assign na       = VW'(req_i.node_a);
  assign na_q     = VW'(req_q.node_a);
  assign nb_q     = VW'(req_q.node_b);
  assign in_range = (32'(req_i.node_a) < MaxVertices) && (32'(req_i.node_b) < MaxVertices);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    r_d         = r_q;
    nxt_d       = nxt_q;
    v_d         = v_q;
    par_d       = par_q;
    dep_d       = dep_q;
    low_d       = low_q;
    cl_d        = cl_q;
    x_d         = x_q;
    topa_d      = topa_q;
    seen_d      = seen_q;
    onp_d       = onp_q;
    brg_d       = brg_q;
    base_d      = base_q;
    got_d       = got_q;
    exist_d     = exist_q;
    phase_d     = phase_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    adj_ctrl    = '0;
    adj_addr    = '0;
    adj_wdata   = '0;
    vtx_we      = 1'b0;
    vtx_re      = 1'b0;
    vtx_waddr   = v_q;
    vtx_raddr   = par_q;
    vtx_wdata   = '{dep: dep_q, par: par_q, nxt: nxt_q, low: low_q};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.req_type)
            REQ_CLEAR: adj_ctrl.clr = 1'b1;
            REQ_ADD: begin
              if (in_range) begin
                adj_ctrl.re = 1'b1;
                adj_addr    = na;
                state_d     = S_ADD_WA;
              end
            end
            REQ_QUERY: begin
              if (in_range) begin
                seen_d  = '0;
                onp_d   = '0;
                brg_d   = '0;
                got_d   = 1'b0;
                exist_d = 1'b0;
                r_d     = '0;
                state_d = S_ROOT;
              end else begin
                res_valid_d = 1'b1;
                res_d       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD_WA: begin
        adj_ctrl.we = 1'b1;
        adj_addr    = na_q;
        adj_wdata   = adj_rdata | (one_v << nb_q);
        state_d     = S_ADD_RB;
      end
      S_ADD_RB: begin
        adj_ctrl.re = 1'b1;
        adj_addr    = nb_q;
        state_d     = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_ctrl.we = 1'b1;
        adj_addr    = nb_q;
        adj_wdata   = adj_rdata | (one_v << na_q);
        state_d     = S_IDLE;
      end
      S_ROOT: begin
        if (r_q == CW'(MaxVertices)) begin
          x_d     = na_q;
          phase_d = 1'b0;
          state_d = S_WALK;
        end else if (seen_q[rr]) begin
          r_d = r_q + 1'b1;
        end else begin
          base_d      = seen_q;
          v_d         = rr;
          par_d       = rr;
          dep_d       = '0;
          low_d       = '0;
          nxt_d       = '0;
          seen_d[rr]  = 1'b1;
          onp_d[rr]   = 1'b1;
          adj_ctrl.re = 1'b1;
          adj_addr    = rr;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (nxt_q == CW'(MaxVertices)) begin
          // all neighbors done: retire the top vertex
          onp_d[v_q] = 1'b0;
          vtx_we     = 1'b1;
          if (dep_q == '0) begin
            if (!got_q && seen_q[na_q] && !base_q[na_q]) begin
              got_d   = 1'b1;
              exist_d = seen_q[nb_q] && !base_q[nb_q];
            end
            r_d     = r_q + 1'b1;
            state_d = S_ROOT;
          end else begin
            // low point not above own depth means no back edge passes the parent
            brg_d[v_q]  = (low_q == dep_q);
            cl_d        = low_q;
            vtx_re      = 1'b1;
            vtx_raddr   = par_q;
            adj_ctrl.re = 1'b1;
            adj_addr    = par_q;
            state_d     = S_RESTORE;
          end
        end else begin
          nxt_d = nxt_q + 1'b1;
          if (adj_rdata[u] && (u != v_q)) begin
            if (!seen_q[u]) begin
              vtx_we        = 1'b1;
              vtx_wdata.nxt = nxt_q + 1'b1;
              v_d           = u;
              par_d         = v_q;
              dep_d         = dep_q + 1'b1;
              low_d         = dep_q + 1'b1;
              nxt_d         = '0;
              seen_d[u]     = 1'b1;
              onp_d[u]      = 1'b1;
              adj_ctrl.re   = 1'b1;
              adj_addr      = u;
            end else if (onp_q[u] && !((dep_q != '0) && (u == par_q))) begin
              vtx_re    = 1'b1;
              vtx_raddr = u;
              state_d   = S_BACK;
            end
          end
        end
      end
      S_BACK: begin
        if (vtx_rd_q.dep < low_q) begin
          low_d = vtx_rd_q.dep;
        end
        state_d = S_SCAN;
      end
      S_RESTORE: begin
        v_d     = par_q;
        par_d   = vtx_rd_q.par;
        dep_d   = vtx_rd_q.dep;
        nxt_d   = vtx_rd_q.nxt;
        low_d   = (cl_q < vtx_rd_q.low) ? cl_q : vtx_rd_q.low;
        state_d = S_SCAN;
      end
      S_WALK: begin
        // climb while the edge to the dfs parent is a bridge
        if (brg_q[x_q]) begin
          vtx_re    = 1'b1;
          vtx_raddr = x_q;
          state_d   = S_WALK_WT;
        end else if (!phase_q) begin
          topa_d  = x_q;
          x_d     = nb_q;
          phase_d = 1'b1;
        end else begin
          res_valid_d       = 1'b1;
          res_d.path_exists = exist_q;
          res_d.path_unique = exist_q && (x_q == topa_q);
          state_d           = S_IDLE;
        end
      end
      S_WALK_WT: begin
        x_d     = vtx_rd_q.par;
        state_d = S_WALK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      seen_q      <= '0;
      onp_q       <= '0;
      brg_q       <= '0;
      base_q      <= '0;
      got_q       <= 1'b0;
      exist_q     <= 1'b0;
      phase_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      seen_q      <= seen_d;
      onp_q       <= onp_d;
      brg_q       <= brg_d;
      base_q      <= base_d;
      got_q       <= got_d;
      exist_q     <= exist_d;
      phase_q     <= phase_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    nxt_q  <= nxt_d;
    v_q    <= v_d;
    par_q  <= par_d;
    dep_q  <= dep_d;
    low_q  <= low_d;
    cl_q   <= cl_d;
    x_q    <= x_d;
    topa_q <= topa_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/bopc_checker.sv =====
// port-level checks of the bridge-only path checker and their bind
module bopc_checker #(
  parameter int MaxVertices = bopc_pkg::MaxVerticesDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input bopc_pkg::in_word_t  req_i,
  input logic                busy_o,
  input logic                res_valid_o,
  input bopc_pkg::out_word_t res_o
);
  import bopc_pkg::*;

  logic take;
  logic good_query;

  assign take       = start_i && !busy_o;
  assign good_query = take && (req_i.req_type == REQ_QUERY) &&
                      (32'(req_i.node_a) < MaxVertices) && (32'(req_i.node_b) < MaxVertices);

  // unique implies connected
  a_unique_needs_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!res_o.path_unique || res_o.path_exists))
    else $error("unique path reported without a path");

  // graph edits never answer
  a_no_word_for_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (req_i.req_type != REQ_QUERY)) |=> !res_valid_o)
    else $error("word delivered for a clear or add");

  // an in-range query runs a search before answering
  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_query |=> (busy_o && !res_valid_o))
    else $error("in-range query did not start a search");

endmodule

bind bridge_only_path_checker bopc_checker #(.MaxVertices(MaxVertices)) u_bopc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== bench/bridge_only_path_checker_chk.sv =====
// checker: predicts unique-path answers from accepted words and compares results
module bridge_only_path_checker_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bopc_pkg::in_word_t  req_i,
  input  logic                busy_o,
  input  logic                res_valid_o,
  input  bopc_pkg::out_word_t res_o,
  output int                  fail_cnt_o,
  output int                  pending_o
);
  import bopc_pkg::*;

  localparam int NV = MaxVerticesDef;

  logic [NV-1:0] graph_rows [NV];
  out_word_t     answer_q [$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_cnt_o++;
  endtask

  // reachability closure from one vertex over a set of rows
  function automatic logic [NV-1:0] closure(input logic [NV-1:0] rows [NV], input int s);
    logic [NV-1:0] cur;
    logic [NV-1:0] nxt;
    cur = '0;
    cur[s] = 1'b1;
    forever begin
      nxt = cur;
      for (int i = 0; i < NV; i++)
        if (cur[i]) nxt |= rows[i];
      if (nxt == cur) return cur;
      cur = nxt;
    end
  endfunction

  // iterative dfs with depth and low point per vertex marks bridges; closures decide the word
  function automatic out_word_t predict_path(input int a, input int b);
    logic [NV-1:0] bridges [NV];
    logic [NV-1:0] seen;
    logic [NV-1:0] onstk;
    int            lvl [NV];
    int            lowp [NV];
    int            stk_v [NV];
    int            stk_n [NV];
    int            sp;
    int            v;
    int            par;
    int            i;
    int            u;
    int            p;
    bit            down;
    bit            has_par;
    logic [NV-1:0] r1;
    logic [NV-1:0] r2;
    out_word_t     w;
    seen = '0;
    onstk = '0;
    for (int k = 0; k < NV; k++) bridges[k] = '0;
    for (int r = 0; r < NV; r++) begin
      if (seen[r]) continue;
      stk_v[0] = r; stk_n[0] = 0; seen[r] = 1; onstk[r] = 1; lvl[r] = 0; lowp[r] = 0;
      sp = 1;
      while (sp > 0) begin
        v = stk_v[sp-1];
        has_par = sp >= 2;
        par = has_par ? stk_v[sp-2] : v;
        i = stk_n[sp-1];
        down = 0;
        while (i < NV) begin
          u = i; i++;
          if (!graph_rows[v][u] || u == v) continue;
          if (!seen[u]) begin
            stk_n[sp-1] = i;
            stk_v[sp] = u; stk_n[sp] = 0; seen[u] = 1; onstk[u] = 1;
            lvl[u] = (lvl[v] + 1) & 63; lowp[u] = lvl[u];
            sp++;
            down = 1;
            break;
          end
          if (onstk[u] && !(has_par && u == par) && lvl[u] < lowp[v]) lowp[v] = lvl[u];
        end
        if (down) continue;
        onstk[v] = 0;
        sp--;
        if (sp > 0) begin
          p = stk_v[sp-1];
          if (lowp[v] > lvl[p]) begin
            bridges[p][v] = 1; bridges[v][p] = 1;
          end else if (lowp[v] < lowp[p]) lowp[p] = lowp[v];
        end
      end
    end
    r1 = closure(graph_rows, a);
    r2 = closure(bridges, a);
    w.path_exists = r1[b];
    w.path_unique = r2[b];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NV; k++) graph_rows[k] = '0;
      answer_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (res_valid_o) begin
        got = res_o;
        if (answer_q.size() == 0) report_mismatch("result word with none expected");
        else begin
          want = answer_q.pop_front();
          if (got.path_exists !== want.path_exists)
            report_mismatch($sformatf("path_exists %b want %b", got.path_exists,
                                      want.path_exists));
          if (got.path_unique !== want.path_unique)
            report_mismatch($sformatf("path_unique %b want %b", got.path_unique,
                                      want.path_unique));
        end
      end
      if (start_i && !busy_o) begin
        case (req_i.req_type)
          REQ_CLEAR: for (int k = 0; k < NV; k++) graph_rows[k] = '0;
          REQ_ADD: begin
            graph_rows[req_i.node_a][req_i.node_b] = 1'b1;
            graph_rows[req_i.node_b][req_i.node_a] = 1'b1;
          end
          REQ_QUERY: answer_q = {answer_q, predict_path(req_i.node_a, req_i.node_b)};
          default: ;
        endcase
      end
    end
    pending_o = answer_q.size();
  end
endmodule

// ===== bench/tb_bridge_only_path_checker.sv =====
// testbench top: clock, reset, request stimulus and verdict
module tb_bridge_only_path_checker;
  import bopc_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_word_t  req_i;
  logic      busy_o;
  logic      res_valid_o;
  out_word_t res_o;
  int        fail_cnt;
  int        pending;
  int        idle_pct;

  bridge_only_path_checker u_top (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .res_valid_o, .res_o
  );

  bridge_only_path_checker_chk u_chk (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .res_valid_o, .res_o,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // present one word at a falling edge and hold it until the block takes it
  task automatic send_word(input logic [1:0] kind, input logic [4:0] a, input logic [4:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= '{req_type: kind, node_a: a, node_b: b};
    start_i <= 1'b1;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_word();
    int r;
    logic [4:0] a;
    logic [4:0] b;
    r = $urandom_range(99);
    a = 5'($urandom_range(11));
    b = 5'($urandom_range(11));
    if ($urandom_range(3) == 0) begin
      a = 5'($urandom); b = 5'($urandom);
    end
    if (r < 3) send_word(REQ_CLEAR, a, b);
    else if (r < 5) send_word(REQ_RSVD, a, b);
    else if (r < 55) send_word(REQ_ADD, a, b);
    else send_word(REQ_QUERY, a, b);
  endtask

  initial begin
    start_i = 0;
    req_i = '0;
    idle_pct = 0;
    rst_ni = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: empty graph, self, extremes, tree, cycle, self loop, repeat
    send_word(REQ_QUERY, 5'd0, 5'd31);
    send_word(REQ_QUERY, 5'd31, 5'd31);
    send_word(REQ_ADD, 5'd0, 5'd31);
    send_word(REQ_ADD, 5'd0, 5'd31);
    send_word(REQ_ADD, 5'd31, 5'd1);
    send_word(REQ_ADD, 5'd2, 5'd2);
    send_word(REQ_QUERY, 5'd0, 5'd1);
    send_word(REQ_QUERY, 5'd2, 5'd0);
    send_word(REQ_ADD, 5'd1, 5'd0);
    send_word(REQ_QUERY, 5'd0, 5'd1);
    send_word(REQ_ADD, 5'd1, 5'd21);
    send_word(REQ_QUERY, 5'd21, 5'd31);
    send_word(REQ_RSVD, 5'd21, 5'd10);
    send_word(REQ_QUERY, 5'd10, 5'd21);
    send_word(REQ_CLEAR, 5'd0, 5'd0);
    send_word(REQ_QUERY, 5'd0, 5'd31);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : (ph == 3) ? 15 : 0;
      for (int n = 0; n < 32; n++) random_word();
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== bridge_only_path_checker.f =====
rtl/bopc_pkg.sv
rtl/bopc_adj_store.sv
rtl/bridge_only_path_checker.sv
rtl/bopc_checker.sv
bench/bridge_only_path_checker_chk.sv
bench/tb_bridge_only_path_checker.sv
